// ===== sv/mccd_pkg.sv =====
// Shared widths, defaults, codes and control structs for the matrix chain cost block.
`default_nettype none

package mccd_pkg;

   localparam int DIM_FIELD_W    = 10;
   localparam int COST_FIELD_W   = 48;
   localparam int SPLIT_FIELD_W  = 6;
   localparam int STATUS_FIELD_W = 2;

   localparam int MAX_DIMS_DEFAULT   = 16;
   localparam int DIM_WIDTH_DEFAULT  = 10;
   localparam int COST_WIDTH_DEFAULT = 48;

   typedef enum logic [STATUS_FIELD_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FEW       = 2'd1,
      STATUS_DROPPED   = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RES_FEW     = 2'd0,
      RES_TRIVIAL = 2'd1,
      RES_TABLE   = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic            dim_we;
      logic            issue;
      logic            first_k;
      logic            last_k;
      logic            load_result;
      result_kind_type kind;
      logic            dropped;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== sv/mccd_channels.sv =====
// Valid/ready channel interfaces for chain dimensions in and chain results out.
`default_nettype none

interface mccd_req_if;
   logic                             valid;
   logic                             ready;
   logic [mccd_pkg::DIM_FIELD_W-1:0] dimension;
   logic                             last;

   modport source (output valid, output dimension, output last, input ready);
   modport sink (input valid, input dimension, input last, output ready);
endinterface

interface mccd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mccd_pkg::COST_FIELD_W-1:0]   min_cost;
   logic [mccd_pkg::SPLIT_FIELD_W-1:0]  best_split;
   logic [mccd_pkg::STATUS_FIELD_W-1:0] status;

   modport source (output valid, output min_cost, output best_split, output status,
                   input ready);
   modport sink (input valid, input min_cost, input best_split, input status,
                 output ready);
endinterface

`default_nettype wire

// ===== sv/mccd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mccd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/mccd_ctrl.sv =====
// Controller: dimension loading, table sweep by chain length, and result hand-off.
`default_nettype none

module mccd_ctrl #(
   parameter int MAX_DIMS = mccd_pkg::MAX_DIMS_DEFAULT,
   localparam int IDX_W = $clog2(MAX_DIMS),
   localparam int CNT_W = $clog2(MAX_DIMS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   output mccd_pkg::ctrl_cmd_type cmd,
   output logic [IDX_W-1:0]       dim_waddr,
   output logic [IDX_W-1:0]       idx_i,
   output logic [IDX_W-1:0]       idx_k,
   output logic [IDX_W-1:0]       idx_j,
   input  mccd_pkg::dp_stat_type  stat
);

   typedef enum logic [3:0] {
      S_LOAD   = 4'b0001,
      S_ISSUE  = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [IDX_W-1:0]          len_ff, len_in;
   logic [IDX_W-1:0]          i_ff, i_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   mccd_pkg::result_kind_type kind_ff, kind_in;

   logic [IDX_W:0]   j_wide;
   logic [IDX_W-1:0] j_idx;
   logic [IDX_W-1:0] k_plus;
   logic [CNT_W-1:0] top_wide;
   logic [IDX_W-1:0] top_idx;
   logic             has_room;
   logic [CNT_W-1:0] n_after;

   assign j_wide   = {1'b0, i_ff} + {1'b0, len_ff} - (IDX_W + 1)'(1);
   assign j_idx    = j_wide[IDX_W-1:0];
   assign k_plus   = k_ff + IDX_W'(1);
   assign top_wide = count_ff - CNT_W'(1);
   assign top_idx  = top_wide[IDX_W-1:0];
   assign has_room = count_ff < CNT_W'(MAX_DIMS);
   assign n_after  = has_room ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      len_in      = len_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      kind_in     = kind_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.kind    = kind_ff;
      cmd.dropped = dropped_ff;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (has_room) begin
                  cmd.dim_we = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  if (n_after < CNT_W'(2)) begin
                     kind_in  = mccd_pkg::RES_FEW;
                     state_in = S_RESULT;
                  end else if (n_after == CNT_W'(2)) begin
                     kind_in  = mccd_pkg::RES_TRIVIAL;
                     state_in = S_RESULT;
                  end else begin
                     kind_in  = mccd_pkg::RES_TABLE;
                     len_in   = IDX_W'(2);
                     i_in     = IDX_W'(1);
                     k_in     = IDX_W'(1);
                     state_in = S_ISSUE;
                  end
               end
            end
         end
         S_ISSUE: begin
            cmd.issue   = 1'b1;
            cmd.first_k = (k_ff == i_ff);
            cmd.last_k  = (k_plus == j_idx);
            if (k_plus == j_idx) begin
               if (j_idx == top_idx) begin
                  state_in = S_DRAIN;
               end else begin
                  i_in = i_ff + IDX_W'(1);
                  k_in = i_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_plus;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               if (len_ff == top_idx) begin
                  state_in = S_RESULT;
               end else begin
                  len_in   = len_ff + IDX_W'(1);
                  i_in     = IDX_W'(1);
                  k_in     = IDX_W'(1);
                  state_in = S_ISSUE;
               end
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_result = 1'b1;
               count_in        = '0;
               dropped_in      = 1'b0;
               state_in        = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      kind_ff <= kind_in;
   end

   assign dim_waddr = count_ff[IDX_W-1:0];
   assign idx_i     = i_ff;
   assign idx_k     = k_ff;
   assign idx_j     = j_idx;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIMS))
      else $error("stored dimension count beyond capacity");

   a_issue_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> (k_ff >= i_ff && k_ff < j_idx && j_idx <= top_idx))
      else $error("split index or cell outside the stored chain");

   a_result_clears : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && stat.out_free) |=> (count_ff == '0 && !dropped_ff))
      else $error("chain not cleared after result hand-off");
`endif

endmodule

`default_nettype wire

// ===== sv/mccd_datapath.sv =====
// Datapath: dimension and cost RAMs, split-cost pipeline, minimum tracking, result register.
`default_nettype none

module mccd_datapath #(
   parameter int MAX_DIMS   = mccd_pkg::MAX_DIMS_DEFAULT,
   parameter int DIM_WIDTH  = mccd_pkg::DIM_WIDTH_DEFAULT,
   parameter int COST_WIDTH = mccd_pkg::COST_WIDTH_DEFAULT,
   localparam int IDX_W = $clog2(MAX_DIMS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [mccd_pkg::DIM_FIELD_W-1:0]      req_dimension,
   input  mccd_pkg::ctrl_cmd_type                cmd,
   input  logic [IDX_W-1:0]                      dim_waddr,
   input  logic [IDX_W-1:0]                      idx_i,
   input  logic [IDX_W-1:0]                      idx_k,
   input  logic [IDX_W-1:0]                      idx_j,
   output mccd_pkg::dp_stat_type                 stat,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [mccd_pkg::COST_FIELD_W-1:0]     rsp_min_cost,
   output logic [mccd_pkg::SPLIT_FIELD_W-1:0]    rsp_best_split,
   output logic [mccd_pkg::STATUS_FIELD_W-1:0]   rsp_status
);

   localparam int DW         = DIM_WIDTH;
   localparam int CW         = COST_WIDTH;
   localparam int P1_W       = 2 * DW;
   localparam int P2_W       = 3 * DW;
   localparam int SUM_W      = ((P2_W > CW) ? P2_W : CW) + 2;
   localparam int CA_W       = 2 * IDX_W;
   localparam int COST_DEPTH = 1 << CA_W;
   localparam logic [CW-1:0] COST_MAX = '1;

   logic [DW-1:0]    dim_wdata;
   logic [DW-1:0]    dim_a, dim_k, dim_j;
   logic [CW-1:0]    cost_l_rd, cost_r_rd;
   logic [IDX_W-1:0] k_plus;
   logic [IDX_W-1:0] i_minus;
   logic             cost_we;
   logic [CW-1:0]    cost_wdata;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic             first1_ff, first2_ff, first3_ff, first4_ff, first5_ff;
   logic             last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic             rz1_ff;
   logic [IDX_W-1:0] k1_ff, k2_ff, k3_ff, k4_ff, k5_ff;
   logic [CA_W-1:0]  wa1_ff, wa2_ff, wa3_ff, wa4_ff, wa5_ff;
   logic [P1_W-1:0]  m1_ff;
   logic [DW-1:0]    pj2_ff;
   logic [CW-1:0]    cl2_ff, cl3_ff;
   logic [CW-1:0]    cr2_ff, cr3_ff, cr4_ff;
   logic [P2_W-1:0]  m2_ff;
   logic [SUM_W-1:0] s4_ff;
   logic [CW-1:0]    q5_ff;
   logic [CW-1:0]    cl1, cr1;
   logic [SUM_W-1:0] total;
   logic [CW-1:0]    q_in;

   logic             take;
   logic [CW-1:0]    best_ff, best_in;
   logic [IDX_W-1:0] bk_ff, bk_in;
   logic             pipe_busy;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mccd_pkg::COST_FIELD_W-1:0]    rsp_cost_ff, rsp_cost_in;
   logic [mccd_pkg::SPLIT_FIELD_W-1:0]   rsp_split_ff, rsp_split_in;
   mccd_pkg::status_type                 rsp_status_ff, rsp_status_in;

   assign dim_wdata = DW'(req_dimension);
   assign k_plus    = idx_k + IDX_W'(1);
   assign i_minus   = idx_i - IDX_W'(1);

   mccd_ram #(.WIDTH(DW), .DEPTH(MAX_DIMS)) u_dim_a (
      .clock(clock), .wr_en(cmd.dim_we), .wr_addr(dim_waddr), .wr_data(dim_wdata),
      .rd_addr(i_minus), .rd_data(dim_a));

   mccd_ram #(.WIDTH(DW), .DEPTH(MAX_DIMS)) u_dim_k (
      .clock(clock), .wr_en(cmd.dim_we), .wr_addr(dim_waddr), .wr_data(dim_wdata),
      .rd_addr(idx_k), .rd_data(dim_k));

   mccd_ram #(.WIDTH(DW), .DEPTH(MAX_DIMS)) u_dim_j (
      .clock(clock), .wr_en(cmd.dim_we), .wr_addr(dim_waddr), .wr_data(dim_wdata),
      .rd_addr(idx_j), .rd_data(dim_j));

   mccd_ram #(.WIDTH(CW), .DEPTH(COST_DEPTH)) u_cost_l (
      .clock(clock), .wr_en(cost_we), .wr_addr(wa5_ff), .wr_data(cost_wdata),
      .rd_addr({idx_i, idx_k}), .rd_data(cost_l_rd));

   mccd_ram #(.WIDTH(CW), .DEPTH(COST_DEPTH)) u_cost_r (
      .clock(clock), .wr_en(cost_we), .wr_addr(wa5_ff), .wr_data(cost_wdata),
      .rd_addr({k_plus, idx_j}), .rd_data(cost_r_rd));

   // Diagonal entries are never written; a single-matrix sub-chain costs nothing.
   assign cl1 = first1_ff ? '0 : cost_l_rd;
   assign cr1 = rz1_ff ? '0 : cost_r_rd;

   assign total = s4_ff + SUM_W'(cr4_ff);
   assign q_in  = (total >= SUM_W'(COST_MAX)) ? COST_MAX : CW'(total);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= cmd.first_k;
      last1_ff  <= cmd.last_k;
      rz1_ff    <= (k_plus == idx_j);
      k1_ff     <= idx_k;
      wa1_ff    <= {idx_i, idx_j};

      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      k2_ff     <= k1_ff;
      wa2_ff    <= wa1_ff;
      m1_ff     <= P1_W'(dim_a) * P1_W'(dim_k);
      pj2_ff    <= dim_j;
      cl2_ff    <= cl1;
      cr2_ff    <= cr1;

      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      k3_ff     <= k2_ff;
      wa3_ff    <= wa2_ff;
      m2_ff     <= P2_W'(m1_ff) * P2_W'(pj2_ff);
      cl3_ff    <= cl2_ff;
      cr3_ff    <= cr2_ff;

      first4_ff <= first3_ff;
      last4_ff  <= last3_ff;
      k4_ff     <= k3_ff;
      wa4_ff    <= wa3_ff;
      s4_ff     <= SUM_W'(m2_ff) + SUM_W'(cl3_ff);
      cr4_ff    <= cr3_ff;

      first5_ff <= first4_ff;
      last5_ff  <= last4_ff;
      k5_ff     <= k4_ff;
      wa5_ff    <= wa4_ff;
      q5_ff     <= q_in;
   end

   // The first split that reaches the minimum is kept.
   assign take       = first5_ff || (q5_ff < best_ff);
   assign cost_wdata = take ? q5_ff : best_ff;
   assign cost_we    = v5_ff && last5_ff;

   always_comb begin
      best_in = best_ff;
      bk_in   = bk_ff;
      if (v5_ff && take) begin
         best_in = q5_ff;
         bk_in   = k5_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bk_ff   <= bk_in;
   end

   assign pipe_busy      = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
   assign stat.pipe_busy = pipe_busy;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_split_in  = rsp_split_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         rsp_cost_in  = '0;
         rsp_split_in = '0;
         case (cmd.kind)
            mccd_pkg::RES_TABLE: begin
               rsp_cost_in  = mccd_pkg::COST_FIELD_W'(best_ff);
               rsp_split_in = mccd_pkg::SPLIT_FIELD_W'(bk_ff);
               if (best_ff == COST_MAX) begin
                  rsp_status_in = mccd_pkg::STATUS_SATURATED;
               end else if (cmd.dropped) begin
                  rsp_status_in = mccd_pkg::STATUS_DROPPED;
               end else begin
                  rsp_status_in = mccd_pkg::STATUS_OK;
               end
            end
            mccd_pkg::RES_TRIVIAL: begin
               rsp_status_in = cmd.dropped ? mccd_pkg::STATUS_DROPPED : mccd_pkg::STATUS_OK;
            end
            default: begin
               rsp_status_in = mccd_pkg::STATUS_FEW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff   <= rsp_cost_in;
      rsp_split_ff  <= rsp_split_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_cost   = rsp_cost_ff;
   assign rsp_best_split = rsp_split_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_result_after_drain : assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !pipe_busy)
      else $error("result captured while cost pipeline still busy");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_write_has_token : assert property (@(posedge clock) disable iff (reset)
      cost_we |-> $past(v1_ff, 4))
      else $error("cost table written without an issued split");
`endif

endmodule

`default_nettype wire

// ===== sv/matrix_chain_cost_dp.sv =====
// Top level of the matrix chain multiplication cost engine.
//
//   channel    dir  handshake         payload
//   req_chan   in   valid/ready       dimension, last
//   rsp_chan   out  valid/ready       min_cost, best_split, status
//
// With last, for n stored dimensions the sweep issues one split per cycle, C(n,3) splits in all,
// and after each of the n-2 chain lengths waits for the cost pipeline to drain; the result is
// then loaded once the output register is free.
// The cost pipeline depth (RAM read, two multiplies, two adds, minimum) sets the drain.
// Reset is synchronous; the RAM contents are not cleared. The result sits in an output
// register, so a new chain is loaded while the previous result waits.
`default_nettype none

module matrix_chain_cost_dp #(
   parameter int MAX_DIMS   = mccd_pkg::MAX_DIMS_DEFAULT,
   parameter int DIM_WIDTH  = mccd_pkg::DIM_WIDTH_DEFAULT,
   parameter int COST_WIDTH = mccd_pkg::COST_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mccd_req_if.sink     req_chan,
   mccd_rsp_if.source   rsp_chan
);

   localparam int IDX_W = $clog2(MAX_DIMS);

   mccd_pkg::ctrl_cmd_type cmd;
   mccd_pkg::dp_stat_type  stat;
   logic [IDX_W-1:0]       dim_waddr;
   logic [IDX_W-1:0]       idx_i;
   logic [IDX_W-1:0]       idx_k;
   logic [IDX_W-1:0]       idx_j;

   mccd_ctrl #(.MAX_DIMS(MAX_DIMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .dim_waddr (dim_waddr),
      .idx_i     (idx_i),
      .idx_k     (idx_k),
      .idx_j     (idx_j),
      .stat      (stat)
   );

   mccd_datapath #(
      .MAX_DIMS   (MAX_DIMS),
      .DIM_WIDTH  (DIM_WIDTH),
      .COST_WIDTH (COST_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_dimension  (req_chan.dimension),
      .cmd            (cmd),
      .dim_waddr      (dim_waddr),
      .idx_i          (idx_i),
      .idx_k          (idx_k),
      .idx_j          (idx_j),
      .stat           (stat),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_min_cost   (rsp_chan.min_cost),
      .rsp_best_split (rsp_chan.best_split),
      .rsp_status     (rsp_chan.status)
   );

endmodule

`default_nettype wire

// ===== dv/matrix_chain_cost_dp_tb.sv =====
// Self-checking testbench for the matrix chain cost engine: directed chains, then random ones.
`default_nettype none

module matrix_chain_cost_dp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIMS = mccd_pkg::MAX_DIMS_DEFAULT;
   localparam int DIM_W    = mccd_pkg::DIM_FIELD_W;
   localparam int COST_W   = mccd_pkg::COST_FIELD_W;
   localparam int SPLIT_W  = mccd_pkg::SPLIT_FIELD_W;
   localparam longint unsigned COST_CAP = (64'd1 << COST_W) - 64'd1;
   localparam int RANDOM_ITEMS = 420;
   localparam int DRAIN_CYCLES = 700;
   localparam int END_WAIT_LIMIT = 20000;
   localparam int NUM_DIRECTED = 24;

   typedef struct packed {
      logic [COST_W-1:0]    min_cost;
      logic [SPLIT_W-1:0]   best_split;
      mccd_pkg::status_type status;
   } chain_result_type;

   typedef struct packed {
      logic [DIM_W-1:0] dimension;
      logic             last;
      logic             typed;
      chain_result_type answer;
   } directed_row_type;

   localparam chain_result_type NO_ANSWER = '{48'd0, 6'd0, mccd_pkg::STATUS_OK};

   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{10'd0,    1'b1, 1'b1, '{48'd0, 6'd0, mccd_pkg::STATUS_FEW}},
      '{10'd1023, 1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b1, 1'b1, '{48'd0, 6'd0, mccd_pkg::STATUS_OK}},
      '{10'd1023, 1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b1, 1'b1, '{48'd2141198334, 6'd1, mccd_pkg::STATUS_OK}},
      '{10'd0,    1'b0, 1'b0, NO_ANSWER},
      '{10'd1,    1'b0, 1'b0, NO_ANSWER},
      '{10'd512,  1'b0, 1'b0, NO_ANSWER},
      '{10'd3,    1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b0, 1'b0, NO_ANSWER},
      '{10'd7,    1'b0, 1'b0, NO_ANSWER},
      '{10'd100,  1'b0, 1'b0, NO_ANSWER},
      '{10'd0,    1'b0, 1'b0, NO_ANSWER},
      '{10'd255,  1'b0, 1'b0, NO_ANSWER},
      '{10'd64,   1'b0, 1'b0, NO_ANSWER},
      '{10'd9,    1'b0, 1'b0, NO_ANSWER},
      '{10'd800,  1'b0, 1'b0, NO_ANSWER},
      '{10'd2,    1'b0, 1'b0, NO_ANSWER},
      '{10'd33,   1'b0, 1'b0, NO_ANSWER},
      '{10'd1000, 1'b0, 1'b0, NO_ANSWER},
      '{10'd17,   1'b0, 1'b0, NO_ANSWER},
      '{10'd1023, 1'b1, 1'b0, NO_ANSWER}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mccd_req_if req_chan();
   mccd_rsp_if rsp_chan();

   matrix_chain_cost_dp DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [DIM_W-1:0]       stored_dims [MAX_DIMS];
   int unsigned            stored_count = 0;
   bit                     chain_dropped = 1'b0;
   chain_result_type       pending_results [$];
   int unsigned            fail_count = 0;
   int unsigned            items_sent = 0;
   int unsigned            chains_sent = 0;
   int unsigned            status_seen [4] = '{0, 0, 0, 0};
   bit                     steady = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned clamp_mul(longint unsigned a, longint unsigned b);
      if (a != 0 && b > COST_CAP / a) begin
         return COST_CAP;
      end
      return a * b;
   endfunction

   function automatic longint unsigned clamp_add(longint unsigned a, longint unsigned b);
      longint unsigned x;
      longint unsigned y;
      x = (a > COST_CAP) ? COST_CAP : a;
      y = (b > COST_CAP) ? COST_CAP : b;
      if (x > COST_CAP - y) begin
         return COST_CAP;
      end
      return x + y;
   endfunction

   function automatic chain_result_type chain_order_cost();
      longint unsigned  cost_tab [MAX_DIMS][MAX_DIMS];
      int unsigned      split_tab [MAX_DIMS][MAX_DIMS];
      longint unsigned  trial;
      longint unsigned  best;
      longint unsigned  whole;
      int unsigned      best_k;
      int unsigned      n;
      int unsigned      j;
      chain_result_type r;
      n = stored_count;
      r.min_cost = '0;
      r.best_split = '0;
      r.status = mccd_pkg::STATUS_FEW;
      if (n < 2) begin
         return r;
      end
      for (int unsigned i = 1; i < n; i++) begin
         cost_tab[i][i] = 0;
         split_tab[i][i] = 0;
      end
      for (int unsigned span = 2; span < n; span++) begin
         for (int unsigned i = 1; i + span - 1 < n; i++) begin
            j = i + span - 1;
            best = 0;
            best_k = 0;
            for (int unsigned k = i; k < j; k++) begin
               trial = clamp_mul(clamp_mul(64'(stored_dims[i-1]), 64'(stored_dims[k])),
                                 64'(stored_dims[j]));
               trial = clamp_add(trial, cost_tab[i][k]);
               trial = clamp_add(trial, cost_tab[k+1][j]);
               if (k == i || trial < best) begin
                  best = trial;
                  best_k = k;
               end
            end
            cost_tab[i][j] = best;
            split_tab[i][j] = best_k;
         end
      end
      whole = cost_tab[1][n-1];
      r.min_cost = whole[COST_W-1:0];
      r.best_split = SPLIT_W'(split_tab[1][n-1]);
      if (whole >= COST_CAP) begin
         r.status = mccd_pkg::STATUS_SATURATED;
      end else if (chain_dropped) begin
         r.status = mccd_pkg::STATUS_DROPPED;
      end else begin
         r.status = mccd_pkg::STATUS_OK;
      end
      return r;
   endfunction

   function automatic bit absorb_dimension(logic [DIM_W-1:0] d, logic is_last,
                                           output chain_result_type r);
      r = NO_ANSWER;
      if (stored_count < MAX_DIMS) begin
         stored_dims[stored_count] = d;
         stored_count++;
      end else begin
         chain_dropped = 1'b1;
      end
      if (!is_last) begin
         return 1'b0;
      end
      r = chain_order_cost();
      stored_count = 0;
      chain_dropped = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_dimension(input logic [DIM_W-1:0] d, input logic is_last,
                                 input bit use_answer, input chain_result_type answer);
      int unsigned      gap;
      chain_result_type predicted;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.dimension <= d;
      req_chan.last <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (absorb_dimension(d, is_last, predicted)) begin
         pending_results.push_back(use_answer ? answer : predicted);
         chains_sent++;
      end
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_result();
      chain_result_type want;
      if (pending_results.size() == 0) begin
         $error("result with nothing expected: min_cost %0d best_split %0d status %0d",
                rsp_chan.min_cost, rsp_chan.best_split, rsp_chan.status);
         fail_count++;
         return;
      end
      want = pending_results.pop_front();
      if (rsp_chan.min_cost !== want.min_cost) begin
         $error("min_cost expected %0d actual %0d", want.min_cost, rsp_chan.min_cost);
         fail_count++;
      end
      if (rsp_chan.best_split !== want.best_split) begin
         $error("best_split expected %0d actual %0d", want.best_split, rsp_chan.best_split);
         fail_count++;
      end
      if (rsp_chan.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, rsp_chan.status);
         fail_count++;
      end
      status_seen[want.status]++;
   endtask

   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_result();
         @(negedge clock);
      end
   end

   initial begin
      int unsigned span;
      int unsigned pick;
      int unsigned chain_index;
      int unsigned waited;
      logic [DIM_W-1:0] d;
      req_chan.valid = 1'b0;
      req_chan.dimension = '0;
      req_chan.last = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         send_dimension(DIRECTED_ROWS[r].dimension, DIRECTED_ROWS[r].last,
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].answer);
      end
      wait_for_results();

      chain_index = 0;
      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         if (chain_index % 8 == 7) begin
            wait_for_results();
         end
         steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            span = 1;
         end else if (pick == 1) begin
            span = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 4);
         end else begin
            span = $urandom_range(2, MAX_DIMS);
         end
         for (int unsigned i = 0; i < span; i++) begin
            case ($urandom_range(0, 7))
               0: begin
                  d = DIM_W'($urandom_range(0, 3));
               end
               1: begin
                  d = $urandom_range(0, 1) ? '1 : '0;
               end
               default: begin
                  d = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
               end
            endcase
            send_dimension(d, i == span - 1, 1'b0, NO_ANSWER);
         end
         chain_index++;
      end
      req_chan.valid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d dimension transactions forming %0d chains.", items_sent, chains_sent);
      $display("Results checked: %0d ok, %0d too short, %0d with dropped dimensions.",
               status_seen[mccd_pkg::STATUS_OK], status_seen[mccd_pkg::STATUS_FEW],
               status_seen[mccd_pkg::STATUS_DROPPED]);
      if (fail_count == 0) begin
         $display("matrix_chain_cost_dp: match");
      end else begin
         $display("matrix_chain_cost_dp: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("matrix_chain_cost_dp: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
